[rtl/npp_pkg.sv]
// Shared types and constants for the neuron potential/phase unit.
// Used by the channel interfaces, every RTL module and the checker.
`default_nettype none

package npp_pkg;

  localparam int unsigned LevelW = 16;
  localparam int unsigned RateW  = 16;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_SET  = 2'd1,
    FN_ADD  = 2'd2,
    FN_ACT  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_RISE = 3'd1,
    PH_FALL = 3'd2,
    PH_UP   = 3'd3,
    PH_DOWN = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CFG_REST = 3'd0,
    CFG_THR  = 3'd1,
    CFG_ACT  = 3'd2,
    CFG_REFR = 3'd3,
    CFG_FAST = 3'd4,
    CFG_SLOW = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [LevelW-1:0] rest;
    logic signed [LevelW-1:0] thr;
    logic signed [LevelW-1:0] act;
    logic signed [LevelW-1:0] refr;
    logic [RateW-1:0]         fast_rate;
    logic [RateW-1:0]         slow_rate;
  } cfg_t;

  localparam logic signed [LevelW-1:0] RestReset = -16'sd17920;

  localparam cfg_t CfgReset = '{
    rest:      -16'sd17920,
    thr:       -16'sd14080,
    act:       16'sd10240,
    refr:      -16'sd23040,
    fast_rate: 16'd6554,
    slow_rate: 16'd3277
  };

  // Transaction held between the input register and the update stage.
  typedef struct packed {
    func_t                    func;
    logic signed [LevelW-1:0] value;
    logic [RateW-1:0]         step_fast;
    logic [RateW-1:0]         step_slow;
  } issue_t;

endpackage

`default_nettype wire

[rtl/npp_if.sv]
// Valid/ready channel interfaces for the neuron potential/phase unit.
// Depends on npp_pkg for the field types.
`default_nettype none

interface npp_in_if;
  logic                             valid;
  logic                             ready;
  npp_pkg::func_t                   func;
  logic signed [npp_pkg::LevelW-1:0] value;
  logic [npp_pkg::RateW-1:0]        time_step;

  modport source (output valid, func, value, time_step, input ready);
  modport sink   (input valid, func, value, time_step, output ready);
endinterface

interface npp_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [npp_pkg::LevelW-1:0] potential;
  npp_pkg::phase_t                  phase;
  logic                             activated;
  logic                             update_done;
  logic                             firing_phase;

  modport source (output valid, potential, phase, activated, update_done, firing_phase,
                  input ready);
  modport sink   (input valid, potential, phase, activated, update_done, firing_phase,
                  output ready);
endinterface

`default_nettype wire

[rtl/npp_cfg.sv]
// APB-style register file holding the six level and rate registers.
// Depends on npp_pkg.
`default_nettype none

module npp_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [npp_pkg::AddrW-1:0]   cfg_paddr,
  input  wire logic [npp_pkg::DataW-1:0]   cfg_pwdata,
  output logic      [npp_pkg::DataW-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output npp_pkg::cfg_t                    cfg
);
  import npp_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;
  logic [LevelW-1:0] rd_val;
  logic [LevelW-1:0] wdata;

  assign idx        = cfg_paddr[AddrW-1:2];
  assign wdata      = cfg_pwdata[LevelW-1:0];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        CFG_REST: cfg_nxt.rest      = wdata;
        CFG_THR:  cfg_nxt.thr       = wdata;
        CFG_ACT:  cfg_nxt.act       = wdata;
        CFG_REFR: cfg_nxt.refr      = wdata;
        CFG_FAST: cfg_nxt.fast_rate = wdata;
        CFG_SLOW: cfg_nxt.slow_rate = wdata;
        default:  cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_REST: rd_val = cfg_r.rest;
      CFG_THR:  rd_val = cfg_r.thr;
      CFG_ACT:  rd_val = cfg_r.act;
      CFG_REFR: rd_val = cfg_r.refr;
      CFG_FAST: rd_val = cfg_r.fast_rate;
      CFG_SLOW: rd_val = cfg_r.slow_rate;
      default:  rd_val = '0;
    endcase
  end

  assign cfg_prdata = {{(DataW-LevelW){1'b0}}, rd_val};
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/npp_issue.sv]
// Input register stage: takes a transaction and precomputes both tick step sizes.
// Depends on npp_pkg and npp_in_if.
`default_nettype none

module npp_issue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  npp_in_if.sink            in_ch,
  input  wire npp_pkg::cfg_t cfg,
  input  wire logic         take,
  output logic              iss_valid,
  output npp_pkg::issue_t   iss
);
  import npp_pkg::*;

  logic                  valid_r;
  logic                  valid_nxt;
  issue_t                iss_r;
  logic                  accept;
  logic [2*RateW-1:0]    prod_fast;
  logic [2*RateW-1:0]    prod_slow;

  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign valid_nxt   = accept || (valid_r && !take);

  // step = (rate * time_step) >> 16
  assign prod_fast = cfg.fast_rate * in_ch.time_step;
  assign prod_slow = cfg.slow_rate * in_ch.time_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      iss_r.func      <= in_ch.func;
      iss_r.value     <= in_ch.value;
      iss_r.step_fast <= prod_fast[2*RateW-1:RateW];
      iss_r.step_slow <= prod_slow[2*RateW-1:RateW];
    end
  end

  assign iss_valid = valid_r;
  assign iss       = iss_r;

endmodule

`default_nettype wire

[rtl/npp_core.sv]
// Update stage: potential and phase state, next-state logic and result register.
// Depends on npp_pkg and npp_out_if.
`default_nettype none

module npp_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire npp_pkg::cfg_t cfg,
  input  wire logic         iss_valid,
  input  wire npp_pkg::issue_t iss,
  output logic              take,
  npp_out_if.source         out_ch
);
  import npp_pkg::*;

  localparam int unsigned WideW = LevelW + 2;

  logic signed [LevelW-1:0] pot_r;
  logic signed [LevelW-1:0] pot_nxt;
  phase_t                   phase_r;
  phase_t                   phase_nxt;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [LevelW-1:0] out_pot_r;
  phase_t                   out_phase_r;
  logic                     out_act_r;

  logic [RateW-1:0]         step;
  logic signed [WideW-1:0]  p_w;
  logic signed [WideW-1:0] step_w;
  logic signed [WideW-1:0]  sum_w;
  logic signed [WideW-1:0]  diff_w;
  logic signed [WideW-1:0]  rest_w;
  logic signed [WideW-1:0]  thr_w;
  logic signed [WideW-1:0]  act_w;
  logic signed [WideW-1:0]  refr_w;

  logic signed [LevelW:0]   add_w;
  logic signed [LevelW-1:0] add_sat;
  logic signed [LevelW-1:0] set_in;
  logic signed [LevelW-1:0] set_clamp;

  assign take          = iss_valid && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = take || (out_valid_r && !out_ch.ready);

  assign step   = (phase_r == PH_RISE || phase_r == PH_FALL) ? iss.step_fast : iss.step_slow;
  assign p_w    = WideW'(pot_r);
  assign step_w = $signed({2'b00, step});
  assign sum_w  = p_w + step_w;
  assign diff_w = p_w - step_w;
  assign rest_w = WideW'(cfg.rest);
  assign thr_w  = WideW'(cfg.thr);
  assign act_w  = WideW'(cfg.act);
  assign refr_w = WideW'(cfg.refr);

  // Saturating add, or the set value for FN_SET, then clamp between refractory and action levels.
  assign add_w = (LevelW+1)'(pot_r) + (LevelW+1)'(iss.value);
  always_comb begin
    if (add_w[LevelW] != add_w[LevelW-1]) begin
      add_sat = add_w[LevelW] ? {1'b1, {(LevelW-1){1'b0}}} : {1'b0, {(LevelW-1){1'b1}}};
    end else begin
      add_sat = add_w[LevelW-1:0];
    end
  end

  assign set_in = (iss.func == FN_SET) ? iss.value : add_sat;

  always_comb begin
    if (set_in < cfg.refr) begin
      set_clamp = cfg.refr;
    end else if (set_in > cfg.act) begin
      set_clamp = cfg.act;
    end else begin
      set_clamp = set_in;
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (iss.func)
      FN_TICK: begin
        case (phase_r)
          PH_RISE: if (sum_w >= act_w)   phase_nxt = PH_FALL;
          PH_FALL: if (diff_w <= refr_w) phase_nxt = PH_UP;
          PH_UP:   if (sum_w >= rest_w)  phase_nxt = PH_IDLE;
          PH_DOWN: if (diff_w <= rest_w) phase_nxt = PH_IDLE;
          default: phase_nxt = phase_r;
        endcase
      end
      FN_SET, FN_ADD: phase_nxt = (set_clamp > cfg.rest) ? PH_DOWN : PH_UP;
      FN_ACT:         phase_nxt = PH_RISE;
      default:        phase_nxt = phase_r;
    endcase
  end

  // Next potential.
  always_comb begin
    pot_nxt = pot_r;
    case (iss.func)
      FN_TICK: begin
        case (phase_r)
          PH_RISE: pot_nxt = (sum_w >= act_w) ? cfg.act : sum_w[LevelW-1:0];
          PH_FALL: begin
            if (diff_w <= refr_w || diff_w < thr_w) begin
              pot_nxt = cfg.refr;
            end else begin
              pot_nxt = diff_w[LevelW-1:0];
            end
          end
          PH_UP:   pot_nxt = (sum_w >= rest_w) ? cfg.rest : sum_w[LevelW-1:0];
          PH_DOWN: pot_nxt = (diff_w <= rest_w) ? cfg.rest : diff_w[LevelW-1:0];
          default: pot_nxt = pot_r;
        endcase
      end
      FN_SET, FN_ADD: pot_nxt = set_clamp;
      FN_ACT:         pot_nxt = cfg.thr;
      default:        pot_nxt = pot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pot_r       <= RestReset;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        pot_r   <= pot_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_pot_r   <= pot_nxt;
      out_phase_r <= phase_nxt;
      out_act_r   <= (pot_nxt >= cfg.thr);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.potential    = out_pot_r;
  assign out_ch.phase        = out_phase_r;
  assign out_ch.activated    = out_act_r;
  assign out_ch.update_done  = (out_phase_r == PH_IDLE);
  assign out_ch.firing_phase = (out_phase_r != PH_IDLE) && (out_phase_r != PH_DOWN);

endmodule

`default_nettype wire

[rtl/neuron_potential_phase_fsm_unit.sv]
// Top level of the neuron potential/phase unit: register file, input stage, update stage.
// Depends on npp_pkg, npp_if, npp_cfg, npp_issue and npp_core.
//
//   Channel   Direction  Handshake            Carries
//   in_ch     sink       valid/ready          func, value, time_step
//   out_ch    source     valid/ready          potential, phase, activated, update_done,
//                                             firing_phase
//   cfg_*     slave      APB psel/penable     six 16-bit level and rate registers
//
// One transaction per cycle sustained while the result is taken; the input register and then
// the result register lie between an input accept and its result valid.
// The input register holds both rate * time_step products, the update stage applies one
// add/compare per transaction against the potential register.
// Synchronous active-low reset: potential to rest level, phase idle, registers to defaults.
// A stalled result holds the update stage; the input register still takes one transaction.
`default_nettype none

module neuron_potential_phase_fsm_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  npp_in_if.sink                           in_ch,
  npp_out_if.source                        out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [npp_pkg::AddrW-1:0]   cfg_paddr,
  input  wire logic [npp_pkg::DataW-1:0]   cfg_pwdata,
  output logic      [npp_pkg::DataW-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import npp_pkg::*;

  cfg_t   cfg;
  issue_t iss;
  logic   iss_valid;
  logic   take;

  npp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  npp_issue u_issue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .take      (take),
    .iss_valid (iss_valid),
    .iss       (iss)
  );

  npp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .iss_valid (iss_valid),
    .iss       (iss),
    .take      (take),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[rtl/npp_checker.sv]
// Port-level checker for the neuron potential/phase unit, bound to the top level.
// Depends on npp_pkg.
`default_nettype none

module npp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_phase,
  input wire logic       out_update_done,
  input wire logic       out_firing_phase
);
  import npp_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Drop any result in flight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_done_decode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_update_done == (out_phase == PH_IDLE)))
    else $error("update_done disagrees with phase");

  a_firing_decode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_firing_phase == (out_phase != PH_IDLE && out_phase != PH_DOWN)))
    else $error("firing_phase disagrees with phase");

endmodule

bind neuron_potential_phase_fsm_unit npp_checker u_npp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_phase        (out_ch.phase),
  .out_update_done  (out_ch.update_done),
  .out_firing_phase (out_ch.firing_phase)
);

`default_nettype wire
